[rtl/kdiag_pkg.sv]
// Package for the diagnostic-link fault reader.
// Holds command codes, link constants, the phase encoding and the result record.
// No dependencies.
package kdiag_pkg;

  // Commands carried with each request.
  localparam logic [1:0] CMD_RX_BYTE    = 2'd0;
  localparam logic [1:0] CMD_SYNC       = 2'd1;
  localparam logic [1:0] CMD_FAULT_READ = 2'd2;
  localparam logic [1:0] CMD_UNUSED     = 2'd3;

  // Outcome codes reported when an operation finishes.
  localparam logic [1:0] OUT_FAULTS     = 2'd0;
  localparam logic [1:0] OUT_NO_FAULTS  = 2'd1;
  localparam logic [1:0] OUT_SYNC_OK    = 2'd2;
  localparam logic [1:0] OUT_SYNC_FAIL  = 2'd3;

  // Bytes seen on the line.
  localparam logic [7:0] SYNC_BYTE      = 8'h55;
  localparam logic [7:0] KEY_LOW        = 8'h01;
  localparam logic [7:0] KEY_HIGH       = 8'h8A;
  localparam logic [7:0] TITLE_READ     = 8'h07;
  localparam logic [7:0] TITLE_ACK      = 8'h09;
  localparam logic [7:0] BLOCK_END      = 8'h03;
  localparam logic [7:0] TITLE_FAULTS   = 8'hFC;
  localparam logic [15:0] NO_FAULT_CODE = 16'hFFFF;
  localparam logic [7:0] NO_FAULT_STAT  = 8'h88;
  localparam logic [7:0] BYTE_ONES      = 8'hFF;

  // Protocol phase. The request and acknowledge block sequences each take seven steps.
  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_SYNC0    = 5'd1,
    PH_SYNC1    = 5'd2,
    PH_SYNC2    = 5'd3,
    PH_SYNCE    = 5'd4,
    PH_REQ0     = 5'd5,
    PH_REQ1     = 5'd6,
    PH_REQ2     = 5'd7,
    PH_REQ3     = 5'd8,
    PH_REQ4     = 5'd9,
    PH_REQ5     = 5'd10,
    PH_REQ6     = 5'd11,
    PH_ACK0     = 5'd12,
    PH_ACK1     = 5'd13,
    PH_ACK2     = 5'd14,
    PH_ACK3     = 5'd15,
    PH_ACK4     = 5'd16,
    PH_ACK5     = 5'd17,
    PH_ACK6     = 5'd18,
    PH_HLEN     = 5'd19,
    PH_HLENE    = 5'd20,
    PH_HCNT     = 5'd21,
    PH_HCNTE    = 5'd22,
    PH_HTTL     = 5'd23,
    PH_HTTLE_FC = 5'd24,
    PH_HTTLE_OT = 5'd25,
    PH_DATA     = 5'd26,
    PH_DATAE    = 5'd27,
    PH_BEND     = 5'd28,
    PH_OEND     = 5'd29
  } phase_t;

  // One result item.
  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        dtc_valid;
    logic [15:0] dtc_code;
    logic [7:0]  dtc_status;
    logic        done_res;
    logic [1:0]  outcome;
  } result_t;

endpackage

[rtl/kdiag_if.sv]
// Handshake channels of the fault reader: request input and result output.
// Depends on kdiag_pkg for nothing but is compiled after it.
interface kdiag_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface kdiag_out_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        dtc_valid;
  logic [15:0] dtc_code;
  logic [7:0]  dtc_status;
  logic        done_res;
  logic [1:0]  outcome;

  modport source (output valid, output tx_valid, output tx_byte, output dtc_valid,
                  output dtc_code, output dtc_status, output done_res, output outcome,
                  input ready);
  modport sink   (input valid, input tx_valid, input tx_byte, input dtc_valid,
                  input dtc_code, input dtc_status, input done_res, input outcome,
                  output ready);
endinterface

[rtl/kdiag_fsm.sv]
// Protocol state machine of the fault reader: phase, block bookkeeping and result logic.
// Depends on kdiag_pkg.
module kdiag_fsm (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [1:0]       cmd,
  input  logic [7:0]       rx_byte,
  output kdiag_pkg::result_t res
);
  import kdiag_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  block_counter_r, block_counter_nxt;
  logic [7:0]  block_length_r, block_length_nxt;
  logic [7:0]  byte_index_r, byte_index_nxt;
  logic [1:0]  triplet_pos_r, triplet_pos_nxt;
  logic [7:0]  code_high_r, code_high_nxt;
  logic [7:0]  code_low_r, code_low_nxt;
  logic        first_triplet_r, first_triplet_nxt;
  logic        faults_found_r, faults_found_nxt;
  logic        sync_mismatch_r, sync_mismatch_nxt;

  logic [7:0]  counter_inc;
  logic [7:0]  rx_compl;
  logic        short_block;
  logic        block_done;
  logic        sync2_bad;
  logic        no_fault_mark;

  assign counter_inc   = block_counter_r + 8'd1;
  assign rx_compl      = BYTE_ONES - rx_byte;
  // A block shorter than four bytes carries no triplet.
  assign short_block   = (block_length_r < 8'd4);
  // Data ends once the index is on a triplet boundary within three of the length.
  assign block_done    = (triplet_pos_r == 2'd0) &&
                         (({1'b0, byte_index_r} + 9'd3) >= {1'b0, block_length_r});
  assign sync2_bad     = sync_mismatch_r || (rx_byte != KEY_HIGH);
  assign no_fault_mark = first_triplet_r && ({code_high_r, code_low_r} == NO_FAULT_CODE) &&
                         (rx_byte == NO_FAULT_STAT);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    case (cmd)
      CMD_SYNC:       phase_nxt = PH_SYNC0;
      CMD_FAULT_READ: phase_nxt = PH_REQ0;
      CMD_UNUSED:     phase_nxt = phase_r;
      default: begin
        case (phase_r)
          PH_IDLE:     phase_nxt = PH_IDLE;
          PH_SYNC0:    phase_nxt = PH_SYNC1;
          PH_SYNC1:    phase_nxt = PH_SYNC2;
          PH_SYNC2:    phase_nxt = sync2_bad ? PH_IDLE : PH_SYNCE;
          PH_SYNCE:    phase_nxt = PH_IDLE;
          PH_REQ0:     phase_nxt = PH_REQ1;
          PH_REQ1:     phase_nxt = PH_REQ2;
          PH_REQ2:     phase_nxt = PH_REQ3;
          PH_REQ3:     phase_nxt = PH_REQ4;
          PH_REQ4:     phase_nxt = PH_REQ5;
          PH_REQ5:     phase_nxt = PH_REQ6;
          PH_REQ6:     phase_nxt = PH_HLEN;
          PH_ACK0:     phase_nxt = PH_ACK1;
          PH_ACK1:     phase_nxt = PH_ACK2;
          PH_ACK2:     phase_nxt = PH_ACK3;
          PH_ACK3:     phase_nxt = PH_ACK4;
          PH_ACK4:     phase_nxt = PH_ACK5;
          PH_ACK5:     phase_nxt = PH_ACK6;
          PH_ACK6:     phase_nxt = PH_HLEN;
          PH_HLEN:     phase_nxt = PH_HLENE;
          PH_HLENE:    phase_nxt = PH_HCNT;
          PH_HCNT:     phase_nxt = PH_HCNTE;
          PH_HCNTE:    phase_nxt = PH_HTTL;
          PH_HTTL:     phase_nxt = (rx_byte == TITLE_FAULTS) ? PH_HTTLE_FC : PH_HTTLE_OT;
          PH_HTTLE_FC: phase_nxt = short_block ? PH_BEND : PH_DATA;
          PH_DATA:     phase_nxt = PH_DATAE;
          PH_DATAE:    phase_nxt = block_done ? PH_BEND : PH_DATA;
          PH_BEND:     phase_nxt = PH_ACK0;
          PH_HTTLE_OT: phase_nxt = PH_OEND;
          PH_OEND:     phase_nxt = PH_IDLE;
          default:     phase_nxt = PH_IDLE;
        endcase
      end
    endcase
  end

  // Block bookkeeping registers.
  always_comb begin
    block_counter_nxt = block_counter_r;
    block_length_nxt  = block_length_r;
    byte_index_nxt    = byte_index_r;
    triplet_pos_nxt   = triplet_pos_r;
    code_high_nxt     = code_high_r;
    code_low_nxt      = code_low_r;
    first_triplet_nxt = first_triplet_r;
    faults_found_nxt  = faults_found_r;
    sync_mismatch_nxt = sync_mismatch_r;
    case (cmd)
      CMD_SYNC: sync_mismatch_nxt = 1'b0;
      CMD_FAULT_READ: begin
        faults_found_nxt  = 1'b1;
        first_triplet_nxt = 1'b1;
      end
      CMD_UNUSED: begin
        sync_mismatch_nxt = sync_mismatch_r;
      end
      default: begin
        case (phase_r)
          PH_SYNC0: sync_mismatch_nxt = (rx_byte != SYNC_BYTE);
          PH_SYNC1: sync_mismatch_nxt = sync_mismatch_r || (rx_byte != KEY_LOW);
          PH_SYNC2: sync_mismatch_nxt = sync2_bad;
          PH_REQ1, PH_ACK1: block_counter_nxt = counter_inc;
          PH_HLEN:  block_length_nxt = rx_byte;
          PH_HCNT:  block_counter_nxt = rx_byte;
          PH_HTTLE_FC: begin
            byte_index_nxt    = 8'd0;
            triplet_pos_nxt   = 2'd0;
            first_triplet_nxt = 1'b1;
          end
          PH_DATA: begin
            byte_index_nxt  = byte_index_r + 8'd1;
            triplet_pos_nxt = (triplet_pos_r == 2'd2) ? 2'd0 : triplet_pos_r + 2'd1;
            case (triplet_pos_r)
              2'd0: code_high_nxt = rx_byte;
              2'd1: code_low_nxt  = rx_byte;
              default: begin
                if (no_fault_mark) begin
                  faults_found_nxt = 1'b0;
                end
                first_triplet_nxt = 1'b0;
              end
            endcase
          end
          default: begin
            block_counter_nxt = block_counter_r;
          end
        endcase
      end
    endcase
  end

  // Result for the current request.
  always_comb begin
    res = '0;
    case (cmd)
      CMD_FAULT_READ: begin
        res.tx_valid = 1'b1;
        res.tx_byte  = BLOCK_END;
      end
      CMD_RX_BYTE: begin
        case (phase_r)
          PH_SYNC2: begin
            if (sync2_bad) begin
              res.done_res = 1'b1;
              res.outcome  = OUT_SYNC_FAIL;
            end else begin
              res.tx_valid = 1'b1;
              res.tx_byte  = rx_compl;
            end
          end
          PH_SYNCE: begin
            res.done_res = 1'b1;
            res.outcome  = OUT_SYNC_OK;
          end
          PH_REQ1, PH_ACK1: begin
            res.tx_valid = 1'b1;
            res.tx_byte  = counter_inc;
          end
          PH_REQ3: begin
            res.tx_valid = 1'b1;
            res.tx_byte  = TITLE_READ;
          end
          PH_ACK3: begin
            res.tx_valid = 1'b1;
            res.tx_byte  = TITLE_ACK;
          end
          PH_REQ5, PH_ACK5, PH_BEND: begin
            res.tx_valid = 1'b1;
            res.tx_byte  = BLOCK_END;
          end
          PH_HLEN, PH_HCNT, PH_HTTL: begin
            res.tx_valid = 1'b1;
            res.tx_byte  = rx_compl;
          end
          PH_DATA: begin
            res.tx_valid = 1'b1;
            res.tx_byte  = rx_compl;
            if ((triplet_pos_r == 2'd2) && !no_fault_mark) begin
              res.dtc_valid  = 1'b1;
              res.dtc_code   = {code_high_r, code_low_r};
              res.dtc_status = rx_byte;
            end
          end
          PH_OEND: begin
            res.done_res = 1'b1;
            res.outcome  = faults_found_r ? OUT_FAULTS : OUT_NO_FAULTS;
          end
          default: begin
            res = '0;
          end
        endcase
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // State registers advance once per processed request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      block_counter_r <= 8'd0;
      block_length_r  <= 8'd0;
      byte_index_r    <= 8'd0;
      triplet_pos_r   <= 2'd0;
      code_high_r     <= 8'd0;
      code_low_r      <= 8'd0;
      first_triplet_r <= 1'b1;
      faults_found_r  <= 1'b1;
      sync_mismatch_r <= 1'b0;
    end else if (step_en) begin
      phase_r         <= phase_nxt;
      block_counter_r <= block_counter_nxt;
      block_length_r  <= block_length_nxt;
      byte_index_r    <= byte_index_nxt;
      triplet_pos_r   <= triplet_pos_nxt;
      code_high_r     <= code_high_nxt;
      code_low_r      <= code_low_nxt;
      first_triplet_r <= first_triplet_nxt;
      faults_found_r  <= faults_found_nxt;
      sync_mismatch_r <= sync_mismatch_nxt;
    end
  end

  // A start of a sync check always lands in the first sync phase.
  a_sync_start: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (cmd == CMD_SYNC) |=> (phase_r == PH_SYNC0))
    else $error("sync start did not enter first sync phase");

  // A finished operation leaves the machine idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.done_res |=> (phase_r == PH_IDLE))
    else $error("machine not idle after reporting done");

  // A fault read restarts the fault flags.
  a_read_flags: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (cmd == CMD_FAULT_READ) |=> faults_found_r && first_triplet_r)
    else $error("fault read did not reset fault flags");

  // Every reported triplet also acknowledges its status byte.
  a_dtc_tx: assert property (@(posedge clk) disable iff (!rst_n)
    res.dtc_valid |-> res.tx_valid && (phase_r == PH_DATA))
    else $error("fault triplet reported outside data phase");

endmodule

[rtl/kline_diag_fault_reader.sv]
// Tester side of a single-wire diagnostic link: sync check and fault-memory read.
// Depends on kdiag_pkg, kdiag_if and kdiag_fsm.
//
// Each request (a start command or one received line byte) gives exactly one result, empty
// or carrying a byte to send, a fault triplet and/or a finished flag with its outcome.
// The block takes one request per clock cycle when not stalled: a request is held in
// the input register, the protocol state machine updates on it, and its result is
// written into the output register once that register is empty or being read.
// Both registers hold under back-pressure, so throughput is one request per cycle
// whenever the result side is ready.
module kline_diag_fault_reader (
  input  logic        clk,
  input  logic        rst_n,
  kdiag_in_if.sink    in_ch,
  kdiag_out_if.source out_ch
);
  import kdiag_pkg::*;

  logic       in_v_r;
  logic [1:0] cmd_r;
  logic [7:0] byte_r;
  logic       out_v_r;
  result_t    res_r;
  result_t    res;
  logic       step_en;

  // Process the held request once the output register can take its result.
  assign step_en     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || step_en;

  kdiag_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .cmd     (cmd_r),
    .rx_byte (byte_r),
    .res     (res)
  );

  // Input register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_r  <= in_ch.command;
      byte_r <= in_ch.rx_byte;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step_en) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.tx_valid   = res_r.tx_valid;
  assign out_ch.tx_byte    = res_r.tx_byte;
  assign out_ch.dtc_valid  = res_r.dtc_valid;
  assign out_ch.dtc_code   = res_r.dtc_code;
  assign out_ch.dtc_status = res_r.dtc_status;
  assign out_ch.done_res   = res_r.done_res;
  assign out_ch.outcome    = res_r.outcome;

endmodule
